[rtl/crl_pkg.sv]
// crl_pkg: shared types and constants for the color ramp lookup block.
// No dependencies; used by every module in rtl.
package crl_pkg;
   localparam int KEY_W = 32;
   localparam int COLOR_W = 24;
   localparam int GAIN_FRAC_BITS = 16;
   localparam logic [7:0] GRAY_LEVEL = 8'd120;
   localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_DUP = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   localparam logic [1:0] CSR_GAIN = 2'd0;
   localparam logic [1:0] CSR_OFFSET = 2'd1;
   localparam logic [1:0] CSR_ALPHA = 2'd2;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic load;      // capture request
      logic scale;     // compute scaled key
      logic scan;      // compare one entry and advance index
      logic shift;     // move one entry up for insert
      logic write;     // write new entry at insert position
      logic div_start; // start lerp division
      logic finish;    // register result
   } ctl_type;

   // datapath to controller status
   typedef struct packed {
      logic is_lookup;
      logic scan_done;
      logic shift_done;
      logic need_div;
      logic div_done;
      logic insert_ok;
   } sts_type;
endpackage

[rtl/crl_ctrl.sv]
// crl_ctrl: sequencer for insert and lookup requests.
// Depends on crl_pkg.
module crl_ctrl
   import crl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output ctl_type ctl
);
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SCALE = 7'b0000010,
      S_SCAN  = 7'b0000100,
      S_SHIFT = 7'b0001000,
      S_WRITE = 7'b0010000,
      S_DIV   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      busy = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            ctl.scale = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (sts.scan_done) begin
               if (!sts.is_lookup) state_in = sts.insert_ok ? S_SHIFT : S_DONE;
               else if (sts.need_div) begin
                  ctl.div_start = 1'b1;
                  state_in = S_DIV;
               end else state_in = S_DONE;
            end else ctl.scan = 1'b1;
         end
         S_SHIFT: begin
            if (sts.shift_done) state_in = S_WRITE;
            else ctl.shift = 1'b1;
         end
         S_WRITE: begin
            ctl.write = 1'b1;
            state_in = S_DONE;
         end
         S_DIV: begin
            if (sts.div_done) state_in = S_DONE;
         end
         S_DONE: begin
            ctl.finish = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

[rtl/crl_div.sv]
// crl_div: restoring divider for the three interpolated channels.
// Depends on crl_pkg; computes floor((2*num + d) / (2*d)) per channel.
module crl_div
   import crl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] den,   // k1-k0, positive
   input  logic [32:0] num_t, // v-k0
   input  logic [23:0] c0,
   input  logic [23:0] c1,
   output logic        done,
   output logic [23:0] quot
);
   // numerator up to 255*2^33, times 2 plus d: below 2^42, held in 43 bits
   localparam int NW = 43;
   localparam int QW = 9;

   logic [NW-1:0] num_ff [3];
   logic [NW-1:0] num_in [3];
   logic [NW-1:0] rem_ff [3];
   logic [NW-1:0] rem_in [3];
   logic [QW-1:0] q_ff [3];
   logic [QW-1:0] q_in [3];
   logic [33:0]   d2_ff;
   logic [5:0]    cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic [1:0]    mstep_ff, mstep_in;
   logic [32:0]   dt;

   assign dt = den - num_t;

   // build numerators serially over the channel, one bit per cycle
   // (shift-add multiply of 8-bit color by 33-bit weight)
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
         mstep_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
         mstep_ff <= mstep_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         num_ff[c] <= num_in[c];
         rem_ff[c] <= rem_in[c];
         q_ff[c] <= q_in[c];
      end
      if (start) d2_ff <= {den, 1'b0};
   end

   always_comb begin
      logic [7:0] a, b;
      logic [NW:0] trial;
      a = '0;
      b = '0;
      trial = '0;
      run_in = run_ff;
      cnt_in = cnt_ff;
      mstep_in = mstep_ff;
      done = 1'b0;
      for (int c = 0; c < 3; c++) begin
         num_in[c] = num_ff[c];
         rem_in[c] = rem_ff[c];
         q_in[c] = q_ff[c];
      end
      if (start) begin
         run_in = 1'b1;
         mstep_in = 2'd1;
         cnt_in = '0;
         for (int c = 0; c < 3; c++) begin
            num_in[c] = '0;
            rem_in[c] = '0;
            q_in[c] = '0;
         end
      end else if (run_ff && mstep_ff == 2'd1) begin
         // multiply phase: one color bit per cycle, most significant bit first
         for (int c = 0; c < 3; c++) begin
            a = c0[8*(2-c) +: 8];
            b = c1[8*(2-c) +: 8];
            num_in[c] = (num_ff[c] << 1)
                      + (a[3'(7 - cnt_ff[2:0])] ? NW'(dt) : '0)
                      + (b[3'(7 - cnt_ff[2:0])] ? NW'(num_t) : '0);
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd7) begin
            mstep_in = 2'd2;
            cnt_in = '0;
            for (int c = 0; c < 3; c++) num_in[c] = (num_in[c] << 1) + NW'(den);
         end
      end else if (run_ff && mstep_ff == 2'd2) begin
         // long division: quotient fits 9 bits, so 9 steps on aligned divisor
         for (int c = 0; c < 3; c++) begin
            trial = {1'b0, num_ff[c]} -
                    ({{(NW - 33){1'b0}}, d2_ff} << (QW - 1 - cnt_ff[3:0]));
            if (!trial[NW]) begin
               num_in[c] = trial[NW-1:0];
               q_in[c] = q_ff[c] | (QW'(1) << (QW - 1 - cnt_ff[3:0]));
            end
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(QW - 1)) begin
            mstep_in = 2'd3;
         end
      end else if (run_ff && mstep_ff == 2'd3) begin
         done = 1'b1;
         run_in = 1'b0;
         mstep_in = 2'd0;
      end
   end

   assign quot = {q_ff[0][7:0], q_ff[1][7:0], q_ff[2][7:0]};
endmodule

[rtl/crl_datapath.sv]
// crl_datapath: breakpoint table, key scaling, search, shift and result.
// Depends on crl_pkg and crl_div.
module crl_datapath
   import crl_pkg::*;
#(
   parameter int MAX_POINTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  ctl_type           ctl,
   output sts_type           sts,
   input  logic              req_cmd,
   input  logic signed [31:0] req_sample_value,
   input  logic [23:0]       req_entry_color,
   input  logic              req_smooth,
   input  logic [31:0]       gain,
   input  logic [31:0]       offset,
   input  logic [7:0]        alpha_level,
   output logic              rsp_valid,
   output logic [7:0]        rsp_red,
   output logic [7:0]        rsp_green,
   output logic [7:0]        rsp_blue,
   output logic [7:0]        rsp_alpha,
   output logic [1:0]        rsp_status
);
   localparam int IW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   logic signed [31:0] key_ff [MAX_POINTS];
   logic [23:0]        col_ff [MAX_POINTS];
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      idx_ff;      // scan position
   logic [CW-1:0]      sh_ff;       // shift position
   logic               cmd_ff, smooth_ff, dup_ff;
   logic signed [31:0] val_ff;      // lookup value or scaled key
   logic [23:0]        color_ff;
   logic signed [63:0] prod_ff;
   logic               scaled_ff;   // set once the new entry is stored
   logic               found_ff;
   logic               rv_ff;
   logic [7:0]         r_ff, g_ff, b_ff, a_ff;
   logic [1:0]         st_ff;
   logic               div_done;
   logic [23:0]        quot;

   // scan entry: index clipped into the table
   logic [IW-1:0]      ix;
   logic signed [31:0] k_cur, k_prev, k_last;
   logic [IW-1:0]      ixp;
   assign ix = idx_ff[IW-1:0];
   assign ixp = IW'(idx_ff - CW'(1));
   assign k_cur = key_ff[ix];
   assign k_prev = key_ff[ixp];
   assign k_last = key_ff[IW'(count_ff - CW'(1))];

   logic signed [64:0] sum;
   logic signed [31:0] key_sat;
   always_comb begin
      sum = 65'(prod_ff + 64'sd32768 >>> GAIN_FRAC_BITS) + 65'(signed'(offset));
      if (sum > 65'sd2147483647) key_sat = 32'sh7fffffff;
      else if (sum < -65'sd2147483648) key_sat = 32'sh80000000;
      else key_sat = sum[31:0];
   end

   logic lookup_stop;
   logic is_end;
   assign is_end = (idx_ff >= count_ff);
   // lookup: stop at i=0 if v<=key[0] or n==1, else scan on until key>=v or i==n-1
   assign lookup_stop = (count_ff == '0)
                     || (idx_ff == '0 && (val_ff <= k_cur || count_ff == CW'(1)))
                     || (idx_ff != '0 && (k_cur >= val_ff || idx_ff == count_ff - CW'(1)));

   logic [32:0] den, tnum;
   assign den = 33'(signed'(k_cur)) - 33'(signed'(k_prev));
   assign tnum = 33'(signed'(val_ff)) - 33'(signed'(k_prev));

   always_comb begin
      sts.is_lookup = cmd_ff;
      sts.scan_done = found_ff;
      sts.shift_done = (sh_ff == idx_ff);
      sts.insert_ok = !dup_ff && (count_ff < CW'(MAX_POINTS));
      sts.need_div = smooth_ff && count_ff != '0 && idx_ff != '0 && val_ff < k_last;
      sts.div_done = div_done;
   end

   crl_div u_div (
      .clock (clock),
      .reset (reset),
      .start (ctl.div_start),
      .den   (den),
      .num_t (tnum),
      .c0    (col_ff[ixp]),
      .c1    (col_ff[ix]),
      .done  (div_done),
      .quot  (quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= ctl.finish;
         if (ctl.write) count_ff <= count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= req_cmd;
         smooth_ff <= req_smooth;
         val_ff <= req_sample_value;
         color_ff <= req_entry_color;
         prod_ff <= req_sample_value * signed'(gain);
         idx_ff <= '0;
         dup_ff <= 1'b0;
         found_ff <= 1'b0;
         scaled_ff <= 1'b0;
      end
      if (ctl.scale) begin
         if (!cmd_ff) val_ff <= key_sat;
         if (cmd_ff && count_ff == '0) found_ff <= 1'b1;
      end
      if (ctl.scan) begin
         if (!cmd_ff) begin
            // insert: find first key >= new key
            if (is_end || k_cur >= val_ff) begin
               found_ff <= 1'b1;
               dup_ff <= !is_end && (k_cur == val_ff);
               sh_ff <= count_ff;
            end else idx_ff <= idx_ff + CW'(1);
         end else begin
            if (lookup_stop) found_ff <= 1'b1;
            else idx_ff <= idx_ff + CW'(1);
         end
      end
      if (ctl.shift) begin
         key_ff[sh_ff[IW-1:0]] <= key_ff[IW'(sh_ff - CW'(1))];
         col_ff[sh_ff[IW-1:0]] <= col_ff[IW'(sh_ff - CW'(1))];
         sh_ff <= sh_ff - CW'(1);
      end
      if (ctl.write) begin
         key_ff[ix] <= val_ff;
         col_ff[ix] <= color_ff;
      end
      if (ctl.finish) begin
         if (!cmd_ff) begin
            {r_ff, g_ff, b_ff, a_ff} <= '0;
            // not a duplicate and not stored: the table was full
            st_ff <= dup_ff ? ST_DUP : (scaled_ff ? ST_OK : ST_FULL);
         end else if (count_ff == '0) begin
            {r_ff, g_ff, b_ff} <= {GRAY_LEVEL, GRAY_LEVEL, GRAY_LEVEL};
            a_ff <= ALPHA_OPAQUE;
            st_ff <= ST_EMPTY;
         end else if (idx_ff == '0) begin
            {r_ff, g_ff, b_ff} <= col_ff[0];
            a_ff <= ALPHA_OPAQUE;
            st_ff <= ST_OK;
         end else if (val_ff >= k_last) begin
            {r_ff, g_ff, b_ff} <= col_ff[ix];
            a_ff <= ALPHA_OPAQUE;
            st_ff <= ST_OK;
         end else if (smooth_ff) begin
            {r_ff, g_ff, b_ff} <= quot;
            a_ff <= alpha_level;
            st_ff <= ST_OK;
         end else begin
            {r_ff, g_ff, b_ff} <= (tnum < 33'(signed'(k_cur)) - 33'(signed'(val_ff)))
                                  ? col_ff[ixp] : col_ff[ix];
            a_ff <= ALPHA_OPAQUE;
            st_ff <= ST_OK;
         end
      end
      if (ctl.write) scaled_ff <= 1'b1;
   end

   assign rsp_valid = rv_ff;
   assign rsp_red = r_ff;
   assign rsp_green = g_ff;
   assign rsp_blue = b_ff;
   assign rsp_alpha = a_ff;
   assign rsp_status = st_ff;
endmodule

[rtl/color_ramp_lookup.sv]
// color_ramp_lookup: top level of the piecewise linear color ramp.
// Depends on crl_pkg, crl_ctrl and crl_datapath.
//
// Usage:
//  - Request channel: drive req_* and raise start; the request is taken at
//    an edge where start is high and busy is low. busy drops in the cycle
//    that shows the result strobe, so the next request can be taken at the
//    edge that ends it.
//  - Result channel: rsp_valid pulses for one cycle with the color, alpha and
//    status. The receiver cannot stall; capture the result in that cycle.
//  - An insert scales the key (one multiply), scans the table one entry per
//    cycle, then, unless the key is a duplicate or the table is full, shifts
//    the tail up one entry per cycle and writes the new entry.
//  - A lookup scans for the bracketing pair one entry per cycle; with smooth
//    set and the value strictly between the first and last keys, a serial
//    shift-add multiply and a 9-step restoring divide follow.
//  - Configuration: csr_write with csr_index 0 gain, 1 offset, 2 alpha;
//    write only while idle. Other indexes are dropped.
//  - Reset: clear the table count and load register defaults; table
//    contents are undefined until written and are never read before then.
module color_ramp_lookup
   import crl_pkg::*;
#(
   parameter int MAX_POINTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_cmd,
   input  logic signed [31:0] req_sample_value,
   input  logic [23:0]       req_entry_color,
   input  logic              req_smooth,
   output logic              rsp_valid,
   output logic [7:0]        rsp_red,
   output logic [7:0]        rsp_green,
   output logic [7:0]        rsp_blue,
   output logic [7:0]        rsp_alpha,
   output logic [1:0]        rsp_status,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);
   logic [31:0] gain_ff, offset_ff;
   logic [7:0]  alpha_ff;
   ctl_type     ctl;
   sts_type     sts;

   // hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= 32'd65536;
         offset_ff <= '0;
         alpha_ff <= ALPHA_OPAQUE;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_GAIN: gain_ff <= csr_data;
            CSR_OFFSET: offset_ff <= csr_data;
            CSR_ALPHA: alpha_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   crl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   crl_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .sts              (sts),
      .req_cmd          (req_cmd),
      .req_sample_value (req_sample_value),
      .req_entry_color  (req_entry_color),
      .req_smooth       (req_smooth),
      .gain             (gain_ff),
      .offset           (offset_ff),
      .alpha_level      (alpha_ff),
      .rsp_valid        (rsp_valid),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_status       (rsp_status)
   );
endmodule

[dv/tb.sv]
// tb: self-checking testbench for color_ramp_lookup (breakpoint insert and color lookup).
// Depends on crl_pkg and the color_ramp_lookup RTL; holds its own color ramp predictor.
module tb;
   import crl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 16;
   localparam int IDLE_LIMIT = 4000;
   localparam int RANDOM_PHASES = 6;
   localparam int ITEMS_PER_PHASE = 155;
   localparam logic [1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [1:0] status;
   } ramp_color_type;

   typedef struct {
      logic        cmd;
      logic [31:0] sample;
      logic [23:0] color;
      logic        smooth;
      bit          known;    // expected color typed in below
      ramp_color_type typed;
   } ramp_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_cmd = CMD_INSERT;
   logic signed [31:0] req_sample_value = '0;
   logic [23:0] req_entry_color = '0;
   logic        req_smooth = 1'b0;
   logic        rsp_valid;
   logic [7:0]  rsp_red, rsp_green, rsp_blue, rsp_alpha;
   logic [1:0]  rsp_status;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = CSR_GAIN;
   logic [31:0] csr_data = '0;

   // predictor copy of the block's registers and breakpoint table
   logic signed [31:0] gain_reg = 32'sd65536;
   logic signed [31:0] offset_reg = '0;
   logic [7:0]         alpha_reg = 8'd255;
   longint             key_tab[TABLE_DEPTH];
   logic [23:0]        color_tab[TABLE_DEPTH];
   int                 point_total = 0;

   ramp_color_type pending_colors[$];
   int          error_count = 0;
   int          idle_cycles = 0;

   color_ramp_lookup #(.MAX_POINTS(TABLE_DEPTH)) uut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // --------------------------------------------------------------------------
   // Predictor
   // --------------------------------------------------------------------------

   // Scale an inserted key: round half up by the 16-bit gain fraction, add the
   // offset, saturate to 32 bits signed.
   function automatic longint scaled_key(longint s);
      longint p;
      longint k;
      p = s * longint'(gain_reg) + (64'sd1 <<< (GAIN_FRAC_BITS - 1));
      k = (p >>> GAIN_FRAC_BITS) + longint'(offset_reg);
      if (k > 64'sd2147483647) k = 64'sd2147483647;
      if (k < -64'sd2147483648) k = -64'sd2147483648;
      return k;
   endfunction

   // Weighted channel mix, rounded half up, exact in 64 bits.
   function automatic logic [7:0] blend(longint c0, longint c1, longint t, longint d);
      longint num;
      num = c0 * (d - t) + c1 * t;
      return 8'((2 * num + d) / (2 * d));
   endfunction

   function automatic ramp_color_type split_color(logic [23:0] c, logic [7:0] a,
                                                  logic [1:0] st);
      ramp_color_type r;
      r.red = c[23:16];
      r.green = c[15:8];
      r.blue = c[7:0];
      r.alpha = a;
      r.status = st;
      return r;
   endfunction

   // Work out the result of one request and advance the predicted table.
   function automatic ramp_color_type ramp_predict(logic cmd, logic [31:0] sample,
                                                   logic [23:0] color, logic smooth);
      longint v;
      longint key;
      longint k0, k1;
      int pos;
      int i;
      logic [23:0] c0, c1;
      v = longint'($signed(sample));
      if (cmd == CMD_INSERT) begin
         key = scaled_key(v);
         pos = 0;
         while (pos < point_total && key_tab[pos] < key) pos++;
         if (pos < point_total && key_tab[pos] == key)
            return split_color('0, '0, ST_DUP);
         if (point_total >= TABLE_DEPTH)
            return split_color('0, '0, ST_FULL);
         for (i = point_total; i > pos; i--) begin
            key_tab[i] = key_tab[i - 1];
            color_tab[i] = color_tab[i - 1];
         end
         key_tab[pos] = key;
         color_tab[pos] = color;
         point_total++;
         return split_color('0, '0, ST_OK);
      end
      if (point_total == 0)
         return split_color({GRAY_LEVEL, GRAY_LEVEL, GRAY_LEVEL}, ALPHA_OPAQUE, ST_EMPTY);
      if (v <= key_tab[0])
         return split_color(color_tab[0], ALPHA_OPAQUE, ST_OK);
      if (v >= key_tab[point_total - 1])
         return split_color(color_tab[point_total - 1], ALPHA_OPAQUE, ST_OK);
      i = 1;
      while (i < point_total - 1 && key_tab[i] < v) i++;
      k0 = key_tab[i - 1];
      k1 = key_tab[i];
      c0 = color_tab[i - 1];
      c1 = color_tab[i];
      if (smooth)
         return split_color({blend(c0[23:16], c1[23:16], v - k0, k1 - k0),
                             blend(c0[15:8], c1[15:8], v - k0, k1 - k0),
                             blend(c0[7:0], c1[7:0], v - k0, k1 - k0)}, alpha_reg, ST_OK);
      // nearest breakpoint; a tie goes to the upper one
      if (v - k0 < k1 - v)
         return split_color(c0, ALPHA_OPAQUE, ST_OK);
      return split_color(c1, ALPHA_OPAQUE, ST_OK);
   endfunction

   // --------------------------------------------------------------------------
   // Driving
   // --------------------------------------------------------------------------

   // Present one request and hold it until taken; called right after a rising
   // edge. Start is left high so back-to-back requests need no second write.
   task automatic issue_request(logic cmd, logic [31:0] sample, logic [23:0] color,
                                logic smooth, bit known, ramp_color_type typed);
      ramp_color_type predicted;
      req_cmd <= cmd;
      req_sample_value <= sample;
      req_entry_color <= color;
      req_smooth <= smooth;
      start <= 1'b1;
      // busy seen at the falling edge is what the next rising edge uses
      do @(negedge clock); while (busy);
      @(posedge clock);
      predicted = ramp_predict(cmd, sample, color, smooth);
      pending_colors.push_back(known ? typed : predicted);
   endtask

   // Drop start, drain every outstanding result and let the block settle.
   task automatic drain_block();
      start <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (index)
         CSR_GAIN:   gain_reg = value;
         CSR_OFFSET: offset_reg = value;
         CSR_ALPHA:  alpha_reg = value[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Pick a lookup or insert value: full range, a small window, a stored key
   // nudged a little, or the midpoint of two stored keys.
   function automatic logic [31:0] pick_sample();
      int j;
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 16383)) - 8192);
         2: begin
            if (point_total == 0) return $urandom;
            j = $urandom_range(0, point_total - 1);
            return 32'(key_tab[j] + $signed($urandom_range(0, 16)) - 8);
         end
         default: begin
            if (point_total < 2) return $urandom_range(0, 4095);
            j = $urandom_range(1, point_total - 1);
            return 32'((key_tab[j - 1] + key_tab[j]) >>> 1);
         end
      endcase
   endfunction

   // --------------------------------------------------------------------------
   // Checking
   // --------------------------------------------------------------------------

   task automatic report_mismatch(string field, int got, int want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
      error_count++;
   endtask

   always @(negedge clock) begin
      ramp_color_type want;
      if (!reset && rsp_valid) begin
         if (pending_colors.size() == 0) begin
            $display("%0t result with no request outstanding", $realtime);
            error_count++;
         end else begin
            want = pending_colors.pop_front();
            if (rsp_red !== want.red) report_mismatch("red", rsp_red, want.red);
            if (rsp_green !== want.green) report_mismatch("green", rsp_green, want.green);
            if (rsp_blue !== want.blue) report_mismatch("blue", rsp_blue, want.blue);
            if (rsp_alpha !== want.alpha) report_mismatch("alpha", rsp_alpha, want.alpha);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(negedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout with %0d results outstanding", pending_colors.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------------

   ramp_row_type directed_rows[$];

   function automatic void add_row(logic cmd, logic [31:0] sample, logic [23:0] color,
                                   logic smooth, bit known = 0,
                                   logic [23:0] rgb = '0, logic [7:0] a = '0,
                                   logic [1:0] st = ST_OK);
      ramp_row_type row;
      row.cmd = cmd;
      row.sample = sample;
      row.color = color;
      row.smooth = smooth;
      row.known = known;
      row.typed = split_color(rgb, a, st);
      directed_rows.push_back(row);
   endfunction

   initial begin
      logic [31:0] phase_gain[RANDOM_PHASES];
      logic [31:0] phase_offset[RANDOM_PHASES];
      logic [7:0]  phase_alpha[RANDOM_PHASES];
      int burst_left;

      phase_gain = '{32'd65536, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, $urandom, 32'd65536};
      phase_offset = '{32'd0, 32'h7FFF_FFFF, 32'h8000_0000, $urandom, $urandom, 32'd0};
      phase_alpha = '{8'd255, 8'd0, 8'd128, 8'($urandom), 8'($urandom), 8'd255};

      // lookup on the empty table, first inserts, duplicate, clamps and ties
      add_row(CMD_LOOKUP, 32'd0, 24'h0, 1'b1, 1, {3{GRAY_LEVEL}}, ALPHA_OPAQUE, ST_EMPTY);
      add_row(CMD_INSERT, 32'h100, 24'hFF0000, 1'b0, 1, 24'h0, 8'd0, ST_OK);
      add_row(CMD_INSERT, 32'h100, 24'h00FF00, 1'b0, 1, 24'h0, 8'd0, ST_DUP);
      add_row(CMD_INSERT, 32'h300, 24'h0000FF, 1'b1, 1, 24'h0, 8'd0, ST_OK);
      add_row(CMD_LOOKUP, 32'h200, 24'h0, 1'b1);
      add_row(CMD_LOOKUP, 32'h200, 24'h0, 1'b0, 1, 24'h0000FF, ALPHA_OPAQUE, ST_OK);
      add_row(CMD_LOOKUP, 32'h1FF, 24'h0, 1'b0);
      add_row(CMD_LOOKUP, 32'h8000_0000, 24'h0, 1'b1, 1, 24'hFF0000, ALPHA_OPAQUE, ST_OK);
      add_row(CMD_LOOKUP, 32'h7FFF_FFFF, 24'h0, 1'b1, 1, 24'h0000FF, ALPHA_OPAQUE, ST_OK);
      add_row(CMD_LOOKUP, 32'h100, 24'h0, 1'b1, 1, 24'hFF0000, ALPHA_OPAQUE, ST_OK);
      add_row(CMD_LOOKUP, 32'h300, 24'h0, 1'b1, 1, 24'h0000FF, ALPHA_OPAQUE, ST_OK);
      add_row(CMD_INSERT, 32'h8000_0000, 24'h123456, 1'b0, 1, 24'h0, 8'd0, ST_OK);
      add_row(CMD_INSERT, 32'h7FFF_FFFF, 24'hABCDEF, 1'b0, 1, 24'h0, 8'd0, ST_OK);
      add_row(CMD_LOOKUP, 32'd0, 24'h0, 1'b1);
      add_row(CMD_LOOKUP, 32'h4000_0000, 24'h0, 1'b1);
      add_row(CMD_LOOKUP, 32'hC000_0000, 24'h0, 1'b0);
      add_row(CMD_LOOKUP, 32'h8000_0001, 24'h0, 1'b1);
      add_row(CMD_INSERT, 32'h200, 24'hFFFFFF, 1'b0, 1, 24'h0, 8'd0, ST_OK);
      add_row(CMD_INSERT, 32'h50, 24'h000000, 1'b1, 1, 24'h0, 8'd0, ST_OK);
      add_row(CMD_LOOKUP, 32'h280, 24'hFFFFFF, 1'b1);
      add_row(CMD_LOOKUP, 32'hFFFF_FFFF, 24'h0, 1'b0);

      // hold reset from time zero, then release it for good
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r])
         issue_request(directed_rows[r].cmd, directed_rows[r].sample, directed_rows[r].color,
                       directed_rows[r].smooth, directed_rows[r].known,
                       directed_rows[r].typed);
      drain_block();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         // reprogram while idle; an unused index must be dropped
         write_csr(CSR_GAIN, phase_gain[ph]);
         write_csr(CSR_OFFSET, phase_offset[ph]);
         write_csr(CSR_ALPHA, {24'($urandom_range(0, 16777215)), phase_alpha[ph]});
         if (ph == 1) write_csr(CSR_SPARE, $urandom);
         burst_left = $urandom_range(1, 20);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            issue_request($urandom_range(0, 3) == 0 ? CMD_INSERT : CMD_LOOKUP,
                          pick_sample(), 24'($urandom), 1'($urandom), 0, '{default: '0});
            // advance through bursts; phase 2 runs with no gaps at all
            burst_left = burst_left - 1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 20);
               if (ph != 2) begin
                  start <= 1'b0;
                  repeat ($urandom_range(1, 15)) @(posedge clock);
               end
            end
         end
         drain_block();
      end

      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

[sim.f]
rtl/crl_pkg.sv
rtl/crl_ctrl.sv
rtl/crl_div.sv
rtl/crl_datapath.sv
rtl/color_ramp_lookup.sv
dv/tb.sv
